[hw/rtl/lbpu_pkg.sv]
// lbpu_pkg: shared constants and types for the lsb-first bit packer and unpacker
// holds operation codes, sequencer states and default sizes
// no dependencies
package lbpu_pkg;

  localparam int unsigned STORE_BYTES_DEF = 1024;
  localparam int unsigned MAX_FIELD_BITS  = 32;
  localparam logic [10:0] CAP_RESET       = 11'd1024;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ_U = 3'd1;
  localparam logic [2:0] OP_READ_S = 3'd2;
  localparam logic [2:0] OP_ALIGN  = 3'd3;
  localparam logic [2:0] OP_REWIND = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

[hw/rtl/lsb_first_bit_packer_unpacker.sv]
// lsb_first_bit_packer_unpacker: packs and unpacks 0 to 32 bit fields lsb first
// into a byte store; one byte-wide ram access per touched byte
// depends on lbpu_pkg and lbpu_ram
// steps: accept cycle, one step per touched byte (a write adds one to clear the byte
// entered at a byte boundary, a read one to collect its last byte), one finish cycle;
// align, rewind and a write that does not fit go from the accept cycle straight to finish
// throughput: one request at a time, set by the single byte port of the store
// reset: rst clears control state, then a clearing pass zeroes every byte of the store
// while requests are stalled; config writes are taken throughout
module lsb_first_bit_packer_unpacker #(
  parameter int unsigned STORE_BYTES = lbpu_pkg::STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] field_value,
  input  logic [5:0]  bit_count,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [31:0] read_value,
  output logic [10:0] used_bytes,
  output logic        overflow
);

  import lbpu_pkg::*;

  localparam int unsigned ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  function automatic logic [7:0] mask8(input logic [3:0] n);
    logic [8:0] t;
    t = (9'd1 << n) - 9'd1;
    return t[7:0];
  endfunction

  state_t state, state_next;

  logic [10:0] capacity;
  logic [10:0] cap_eff, cap_q, cap_q_next;
  logic [10:0] byte_pos, byte_pos_next;
  logic [2:0]  bit_pos, bit_pos_next;
  logic        ovf, ovf_next;
  logic [2:0]  op_q, op_q_next;
  logic [5:0]  nb_q, nb_q_next;
  logic [31:0] data, data_next;
  logic [5:0]  left, left_next;
  logic [5:0]  done, done_next;
  logic [31:0] acc, acc_next;
  logic        merge, merge_next;
  logic        pend_valid, pend_valid_next;
  logic [2:0]  pend_shift, pend_shift_next;
  logic [3:0]  pend_n, pend_n_next;
  logic [5:0]  pend_done, pend_done_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;

  logic        res_load;
  logic [31:0] res_value;
  logic [31:0] low_mask;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // dispatch checks
  logic        accept;
  logic [5:0]  nb_sat;
  logic [13:0] pos, capbits, rem;
  logic        fits;
  logic [5:0]  rd_left;
  logic        rd_ovf;

  // shared byte step unit
  logic [3:0]  room, step_n, step_sum;
  logic [7:0]  chunk, wbyte, rbits;
  logic [10:0] next_byte;

  lbpu_ram #(
    .WIDTH  (8),
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign res_load  = (state == ST_FINISH) && (!res_valid || !res_stall);

  always_comb begin
    cap_eff = (capacity == 11'd0) ? 11'd1 : capacity;
    if (32'(cap_eff) > STORE_BYTES) begin
      cap_eff = 11'(STORE_BYTES);
    end
  end

  always_comb begin
    nb_sat  = (bit_count > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : bit_count;
    pos     = {byte_pos, bit_pos};
    capbits = {cap_eff, 3'b000};
    fits    = ({1'b0, pos} + 15'(nb_sat)) <= {1'b0, capbits};
    rem     = capbits - pos;
    rd_left = nb_sat;
    rd_ovf  = 1'b0;
    if (pos > capbits) begin
      rd_left = 6'd0;
      rd_ovf  = 1'b1;
    end else if (14'(nb_sat) > rem) begin
      rd_left = rem[5:0];
      rd_ovf  = 1'b1;
    end
  end

  always_comb begin
    room      = 4'd8 - {1'b0, bit_pos};
    step_n    = (left < {2'b00, room}) ? left[3:0] : room;
    step_sum  = {1'b0, bit_pos} + step_n;
    chunk     = data[7:0] & mask8(step_n);
    wbyte     = (merge ? mem_rdata : 8'd0) | (chunk << bit_pos);
    rbits     = (mem_rdata >> pend_shift) & mask8(pend_n);
    next_byte = byte_pos + 11'd1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_WRITE:             state_next = fits ? ST_WRITE : ST_FINISH;
            OP_READ_U, OP_READ_S: state_next = ST_READ;
            default:              state_next = ST_FINISH;
          endcase
        end
      end
      ST_WRITE:  state_next = (step_sum == 4'd8) ? ST_WRITE : ST_FINISH;
      ST_READ:   state_next = (left == 6'd0) ? ST_FINISH : ST_READ;
      ST_FINISH: state_next = res_load ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    low_mask  = (nb_q >= 6'd32) ? '1 : ((32'd1 << nb_q) - 32'd1);
    res_value = 32'd0;
    if (op_q == OP_READ_U || op_q == OP_READ_S) begin
      res_value = acc;
      if (op_q == OP_READ_S && nb_q != 6'd0 && acc[5'(nb_q - 6'd1)]) begin
        res_value = acc | ~low_mask;
      end
    end
  end

  always_comb begin
    byte_pos_next   = byte_pos;
    bit_pos_next    = bit_pos;
    ovf_next        = ovf;
    op_q_next       = op_q;
    nb_q_next       = nb_q;
    cap_q_next      = cap_q;
    data_next       = data;
    left_next       = left;
    done_next       = done;
    acc_next        = acc;
    merge_next      = merge;
    pend_valid_next = 1'b0;
    pend_shift_next = pend_shift;
    pend_n_next     = pend_n;
    pend_done_next  = pend_done;
    clr_addr_next   = clr_addr;
    mem_we          = 1'b0;
    mem_waddr       = ADDR_W'(byte_pos);
    mem_wdata       = 8'd0;
    mem_raddr       = ADDR_W'(byte_pos);
    case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          op_q_next  = operation;
          nb_q_next  = nb_sat;
          cap_q_next = cap_eff;
          data_next  = field_value;
          acc_next   = 32'd0;
          done_next  = 6'd0;
          left_next  = 6'd0;
          // first byte of a write keeps its low bits when the field starts mid-byte
          merge_next = (bit_pos != 3'd0);
          case (operation)
            OP_WRITE: begin
              if (fits) begin
                left_next = nb_sat;
              end else begin
                ovf_next      = 1'b1;
                bit_pos_next  = 3'd0;
                byte_pos_next = cap_eff;
              end
            end
            OP_READ_U, OP_READ_S: begin
              left_next = rd_left;
              if (rd_ovf) begin
                ovf_next = 1'b1;
              end
            end
            OP_ALIGN: begin
              if (bit_pos != 3'd0) begin
                byte_pos_next = next_byte;
                bit_pos_next  = 3'd0;
                if (next_byte < cap_eff) begin
                  mem_we    = 1'b1;
                  mem_waddr = ADDR_W'(next_byte);
                end
              end
            end
            OP_REWIND: begin
              byte_pos_next = 11'd0;
              bit_pos_next  = 3'd0;
              ovf_next      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        mem_we    = (byte_pos < cap_q);
        mem_wdata = wbyte;
        if (step_sum == 4'd8) begin
          // byte complete: move on, the next step writes (and so clears) the new byte
          byte_pos_next = next_byte;
          bit_pos_next  = 3'd0;
          left_next     = left - 6'(step_n);
          data_next     = data >> step_n;
          merge_next    = 1'b0;
        end else begin
          bit_pos_next = step_sum[2:0];
        end
      end
      ST_READ: begin
        if (pend_valid) begin
          acc_next = acc | (32'(rbits) << pend_done);
        end
        if (left != 6'd0) begin
          pend_valid_next = 1'b1;
          pend_shift_next = bit_pos;
          pend_n_next     = step_n;
          pend_done_next  = done;
          done_next       = done + 6'(step_n);
          left_next       = left - 6'(step_n);
          if (step_sum == 4'd8) begin
            byte_pos_next = next_byte;
            bit_pos_next  = 3'd0;
          end else begin
            bit_pos_next = step_sum[2:0];
          end
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      capacity   <= CAP_RESET;
      byte_pos   <= 11'd0;
      bit_pos    <= 3'd0;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      clr_addr   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      byte_pos   <= byte_pos_next;
      bit_pos    <= bit_pos_next;
      ovf        <= ovf_next;
      pend_valid <= pend_valid_next;
      clr_addr   <= clr_addr_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    nb_q       <= nb_q_next;
    cap_q      <= cap_q_next;
    data       <= data_next;
    left       <= left_next;
    done       <= done_next;
    acc        <= acc_next;
    merge      <= merge_next;
    pend_shift <= pend_shift_next;
    pend_n     <= pend_n_next;
    pend_done  <= pend_done_next;
    if (res_load) begin
      read_value <= res_value;
      used_bytes <= byte_pos + {10'd0, (bit_pos != 3'd0)};
      overflow   <= ovf;
    end
  end

  // a write that fitted never steps past the end of the store in use
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (byte_pos <= cap_q))
    else $error("write step beyond capacity");

  // every byte fetched by a read lies inside capacity
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && left != 6'd0) |-> (byte_pos < cap_q))
    else $error("read fetch beyond capacity");

  // fetched data is only pending while the read sequence runs
  a_pend_in_read: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_READ))
    else $error("pending read data outside read sequence");

  // no result is produced during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !$rose(res_valid))
    else $error("result raised during clearing pass");

endmodule

[hw/rtl/lbpu_ram.sv]
// lbpu_ram: generic single write port, single read port ram with registered read
// width and depth set by parameters
// no dependencies
module lbpu_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/lsb_first_bit_packer_unpacker_tb.sv]
// lsb_first_bit_packer_unpacker_tb: self-checking bench for the lsb-first bit packer
// a shadow of the byte store predicts each result unless a directed row gives it; directed table first, then random
// depends on lbpu_pkg and lsb_first_bit_packer_unpacker
module lsb_first_bit_packer_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbpu_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int ITEMS_TARGET   = 650;
  localparam int PHASE_ITEMS    = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 16;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [10:0] used;
    logic        ovf;
  } result_t;

  typedef struct packed {
    logic        is_cap;
    logic [10:0] cap;
    logic [2:0]  op;
    logic [31:0] val;
    logic [5:0]  cnt;
    logic        known;
    result_t     res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  operation = OP_WRITE;
  logic [31:0] field_value = '0;
  logic [5:0]  bit_count = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [31:0] read_value;
  logic [10:0] used_bytes;
  logic        overflow;

  lsb_first_bit_packer_unpacker dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .field_value(field_value),
    .bit_count  (bit_count),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .read_value (read_value),
    .used_bytes (used_bytes),
    .overflow   (overflow)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the packer state
  logic [7:0]  shadow_bytes [STORE_BYTES_DEF];
  logic [10:0] shadow_byte_pos;
  int          shadow_bit_pos;
  logic        shadow_overflow;
  logic [10:0] shadow_capacity;

  result_t   results_due [$];
  stim_row_t dir_rows [$];

  int mismatch_count = 0;
  int requests_sent  = 0;
  int items_counted  = 0;
  int results_seen   = 0;
  int overflow_seen  = 0;
  int cap_writes     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  int stall_tick     = 0;
  int stall_mode     = 0;

  function automatic int capacity_in_use();
    if (shadow_capacity == 0) return 1;
    if (shadow_capacity > STORE_BYTES_DEF) return STORE_BYTES_DEF;
    return shadow_capacity;
  endfunction

  task automatic clear_byte();
    if (shadow_byte_pos < capacity_in_use()) shadow_bytes[shadow_byte_pos] = '0;
  endtask

  task automatic next_byte();
    shadow_byte_pos = shadow_byte_pos + 11'd1;
    shadow_bit_pos = 0;
  endtask

  task automatic bitstream_step(input logic [2:0] op, input logic [31:0] val,
                                input logic [5:0] cnt, output result_t res);
    int nb, capb, capbits, pos, left, n, excess, done;
    logic [63:0] v, acc;
    logic [7:0] b;
    nb = (cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(cnt);
    capb = capacity_in_use();
    capbits = 8 * capb;
    pos = 8 * int'(shadow_byte_pos) + shadow_bit_pos;
    acc = '0;
    case (op)
      OP_WRITE: begin
        if (pos + nb > capbits) begin
          // field does not fit: nothing stored, jump to the end
          shadow_overflow = 1'b1;
          shadow_bit_pos = 0;
          shadow_byte_pos = 11'(capb);
        end else begin
          if (shadow_bit_pos == 0) clear_byte();
          v = 64'(val);
          left = nb;
          while (left > 0) begin
            n = 8 - shadow_bit_pos;
            if (n > left) n = left;
            if (shadow_byte_pos < capb)
              shadow_bytes[shadow_byte_pos] |= 8'((v & ((64'd1 << n) - 1)) << shadow_bit_pos);
            shadow_bit_pos += n;
            if (shadow_bit_pos != 8) break;
            next_byte();
            clear_byte();
            left -= n;
            v = v >> n;
          end
        end
      end
      OP_READ_U, OP_READ_S: begin
        excess = (pos + nb > capbits) ? pos + nb - capbits : 0;
        left = (excess > nb) ? 0 : nb - excess;
        if (excess != 0) shadow_overflow = 1'b1;
        done = 0;
        while (left > 0) begin
          n = 8 - shadow_bit_pos;
          if (n > left) n = left;
          b = (shadow_byte_pos < capb) ? shadow_bytes[shadow_byte_pos] : 8'd0;
          acc |= 64'((b >> shadow_bit_pos) & ((1 << n) - 1)) << done;
          done += n;
          left -= n;
          shadow_bit_pos += n;
          if (shadow_bit_pos == 8) next_byte();
        end
        // sign bit may itself be one of the zero-filled bits
        if (op == OP_READ_S && nb > 0 && acc[nb-1]) acc |= ~((64'd1 << nb) - 1);
      end
      OP_ALIGN: begin
        if (shadow_bit_pos != 0) begin
          next_byte();
          clear_byte();
        end
      end
      OP_REWIND: begin
        shadow_byte_pos = '0;
        shadow_bit_pos = 0;
        shadow_overflow = 1'b0;
      end
      default: ;
    endcase
    res.value = acc[31:0];
    res.used = shadow_byte_pos + 11'(shadow_bit_pos != 0);
    res.ovf = shadow_overflow;
  endtask

  // one request through the handshake; the sender works in bursts with random gaps, possibly none, between
  task automatic send_req(input logic [2:0] op, input logic [31:0] val, input logic [5:0] cnt,
                          input logic known = 1'b0, input result_t known_res = '0);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    operation <= op;
    field_value <= val;
    bit_count <= cnt;
    do @(posedge clk); while (req_stall);
    bitstream_step(op, val, cnt, r);
    results_due.push_back(known ? known_res : r);
    requests_sent++;
    if (op <= OP_REWIND) items_counted++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [10:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = cap;
    cap_writes++;
  endtask

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 6'd0;
    if (r == 1) return 6'd32;
    if (r == 2) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(1, 31));
  endfunction

  // fields written after a rewind, then read back with the same sizes
  task automatic round_trip();
    int n_fields;
    logic [5:0] counts [8];
    bit aligns [8];
    n_fields = $urandom_range(1, 8);
    send_req(OP_REWIND, $urandom, pick_count());
    for (int i = 0; i < n_fields; i++) begin
      counts[i] = pick_count();
      aligns[i] = ($urandom_range(0, 4) == 0);
      send_req(OP_WRITE, $urandom, counts[i]);
      if (aligns[i]) send_req(OP_ALIGN, $urandom, pick_count());
    end
    send_req(OP_REWIND, $urandom, pick_count());
    for (int i = 0; i < n_fields + $urandom_range(0, 1); i++) begin
      send_req($urandom_range(0, 1) ? OP_READ_S : OP_READ_U, $urandom,
               (i < n_fields) ? counts[i] : pick_count());
      if (i < n_fields && aligns[i]) send_req(OP_ALIGN, $urandom, pick_count());
    end
  endtask

  function automatic stim_row_t mk_req(input logic [2:0] op, input logic [31:0] val,
                                       input logic [5:0] cnt);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.val = val;
    row.cnt = cnt;
    return row;
  endfunction

  function automatic stim_row_t mk_known(input logic [2:0] op, input logic [31:0] val,
                                         input logic [5:0] cnt, input logic [31:0] rv,
                                         input logic [10:0] used, input logic ovf);
    stim_row_t row;
    row = mk_req(op, val, cnt);
    row.known = 1'b1;
    row.res = '{value: rv, used: used, ovf: ovf};
    return row;
  endfunction

  function automatic stim_row_t mk_cap(input logic [10:0] cap);
    stim_row_t row;
    row = '0;
    row.is_cap = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  // receiver: stall pattern switches between random and periodic modes
  always @(posedge clk) begin
    result_t got, want;
    stall_tick++;
    if (stall_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      2: res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= stall_tick[2];
    endcase
    if (!rst && res_valid && !res_stall) begin
      got = '{value: read_value, used: used_bytes, ovf: overflow};
      results_seen++;
      if (overflow) overflow_seen++;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR %0t: result with nothing outstanding: value %h used %0d ovf %b",
                   $realtime, got.value, got.used, got.ovf);
      end else begin
        want = results_due.pop_front();
        if (got.value !== want.value || got.used !== want.used || got.ovf !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR %0t: value %h/%h used %0d/%0d ovf %b/%b (got/want)",
                     $realtime, got.value, want.value, got.used, want.used, got.ovf, want.ovf);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, results_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int phase;
    logic [10:0] cap;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
    shadow_byte_pos = '0;
    shadow_bit_pos = 0;
    shadow_overflow = 1'b0;
    shadow_capacity = CAP_RESET;

    dir_rows.push_back(mk_known(OP_WRITE, 32'h0, 6'd0, 32'h0, 11'd0, 1'b0));
    dir_rows.push_back(mk_known(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 32'h0, 11'd4, 1'b0));
    // count above the maximum saturates to 32 bits
    dir_rows.push_back(mk_known(OP_WRITE, 32'h0, 6'd63, 32'h0, 11'd8, 1'b0));
    dir_rows.push_back(mk_known(OP_REWIND, 32'h0, 6'd0, 32'h0, 11'd0, 1'b0));
    dir_rows.push_back(mk_known(OP_READ_U, 32'h0, 6'd32, 32'hFFFF_FFFF, 11'd4, 1'b0));
    dir_rows.push_back(mk_known(OP_READ_S, 32'h0, 6'd32, 32'h0, 11'd8, 1'b0));
    dir_rows.push_back(mk_known(OP_REWIND, 32'h0, 6'd0, 32'h0, 11'd0, 1'b0));
    dir_rows.push_back(mk_req(OP_WRITE, 32'h5, 6'd3));
    dir_rows.push_back(mk_req(OP_WRITE, 32'h1FF, 6'd9));
    dir_rows.push_back(mk_req(OP_ALIGN, 32'h0, 6'd0));
    dir_rows.push_back(mk_req(OP_ALIGN, 32'h0, 6'd0));
    dir_rows.push_back(mk_req(OP_REWIND, 32'h0, 6'd0));
    dir_rows.push_back(mk_req(OP_READ_S, 32'h0, 6'd3));
    dir_rows.push_back(mk_req(OP_READ_S, 32'h0, 6'd0));
    dir_rows.push_back(mk_req(OP_READ_U, 32'hDEAD, 6'd9));
    dir_rows.push_back(mk_req(OP_SPARE_FIRST, 32'hFFFF_FFFF, 6'd32));
    dir_rows.push_back(mk_req(OP_SPARE_LAST, 32'h0, 6'd1));
    // zero capacity behaves as one byte
    dir_rows.push_back(mk_cap(11'd0));
    dir_rows.push_back(mk_req(OP_REWIND, 32'h0, 6'd0));
    dir_rows.push_back(mk_req(OP_WRITE, 32'hAB, 6'd8));
    dir_rows.push_back(mk_known(OP_WRITE, 32'h1, 6'd1, 32'h0, 11'd1, 1'b1));
    dir_rows.push_back(mk_req(OP_REWIND, 32'h0, 6'd0));
    dir_rows.push_back(mk_req(OP_READ_U, 32'h0, 6'd12));
    dir_rows.push_back(mk_req(OP_READ_S, 32'h0, 6'd4));
    dir_rows.push_back(mk_cap(11'd2047));
    dir_rows.push_back(mk_req(OP_WRITE, 32'h1234_5678, 6'd32));
    // capacity dropped below the current position
    dir_rows.push_back(mk_cap(11'd2));
    dir_rows.push_back(mk_req(OP_READ_U, 32'h0, 6'd8));
    dir_rows.push_back(mk_req(OP_WRITE, 32'h0, 6'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cap) set_capacity(dir_rows[i].cap);
      else send_req(dir_rows[i].op, dir_rows[i].val, dir_rows[i].cnt,
                    dir_rows[i].known, dir_rows[i].res);
    end

    // fill the whole store until a write no longer fits, then read some back
    set_capacity(CAP_RESET);
    send_req(OP_REWIND, $urandom, pick_count());
    while (!shadow_overflow) begin
      if ($urandom_range(0, 15) == 0) send_req(OP_ALIGN, $urandom, pick_count());
      else send_req(OP_WRITE, $urandom, ($urandom_range(0, 7) == 0) ?
                    6'($urandom_range(33, 63)) : 6'($urandom_range(24, 32)));
    end
    send_req(OP_READ_U, $urandom, pick_count());
    send_req(OP_REWIND, $urandom, pick_count());
    repeat (10) send_req($urandom_range(0, 1) ? OP_READ_S : OP_READ_U, $urandom, pick_count());

    phase = 0;
    while (items_counted < ITEMS_TARGET) begin
      case (phase % 6)
        0: cap = 11'($urandom_range(1, 4));
        1: cap = 11'd0;
        2: cap = 11'($urandom_range(5, 16));
        3: cap = 11'($urandom_range(17, 200));
        4: cap = 11'($urandom_range(1025, 2047));
        default: cap = 11'd1;
      endcase
      set_capacity(cap);
      phase++;
      // no rewind at phase start, so a lowered capacity meets the old position
      for (int start = items_counted; items_counted - start < PHASE_ITEMS; ) begin
        if ($urandom_range(0, 3) != 0) round_trip();
        else send_req(3'($urandom_range(0, 7)), $urandom, 6'($urandom_range(0, 63)));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d results (%0d with overflow) over %0d capacity writes",
             requests_sent, results_seen, overflow_seen, cap_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lbpu_pkg.sv
hw/rtl/lbpu_ram.sv
hw/rtl/lsb_first_bit_packer_unpacker.sv
sim/lsb_first_bit_packer_unpacker_tb.sv
